// ----- rtl/v3a_pkg.sv -----
package v3a_pkg;

    localparam logic [3:0] OP_ADD   = 4'd0;
    localparam logic [3:0] OP_SUB   = 4'd1;
    localparam logic [3:0] OP_CROSS = 4'd2;
    localparam logic [3:0] OP_SCALE = 4'd3;
    localparam logic [3:0] OP_DIV   = 4'd4;
    localparam logic [3:0] OP_COS   = 4'd5;
    localparam logic [3:0] OP_GT    = 4'd6;
    localparam logic [3:0] OP_GE    = 4'd7;
    localparam logic [3:0] OP_LT    = 4'd8;
    localparam logic [3:0] OP_LE    = 4'd9;
    localparam logic [3:0] OP_EQ    = 4'd10;
    localparam logic [3:0] OP_NE    = 4'd11;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_DIVZ = 2'd1;
    localparam logic [1:0] ST_SAT  = 2'd2;

    localparam int SqSteps  = 32;
    localparam int DivSteps = 24;
    localparam int CosSteps = 15;

    localparam logic [14:0] COS_ONE = 15'd16384;

    typedef struct packed {
        logic [3:0]        op;
        logic [2:0][15:0]  vres;
        logic              vsat;
        logic              flag;
        logic              dz;
        logic [2:0][23:0]  div_num;
        logic [2:0][15:0]  div_rem;
        logic [2:0][15:0]  div_den;
        logic [2:0]        div_neg;
        logic [63:0]       sq_op;
        logic [63:0]       sq_res;
        logic [31:0]       mag;
        logic              d_neg;
        logic [31:0]       cos_rem;
        logic [14:0]       cos_q;
    } work_t;

    // saturation flag in the top bit
    function automatic logic [16:0] sat16(input logic signed [33:0] v);
        logic [16:0] r;
        if (v > 34'sd32767) begin
            r = {1'b1, 16'h7fff};
        end else if (v < -34'sd32768) begin
            r = {1'b1, 16'h8000};
        end else begin
            r = {1'b0, v[15:0]};
        end
        return r;
    endfunction

    // q16.16 to q8.8, round half up
    function automatic logic signed [33:0] rnd8(input logic signed [33:0] v);
        return (v + 34'sd128) >>> 8;
    endfunction

endpackage

// ----- rtl/vector3_alu.sv -----
// channel  dir  handshake            payload
// s_       in   s_tvalid / s_tready  s_tdata 112 bit, s_tuser 4 bit opcode
// m_       out  m_tvalid / m_tready  m_tdata 72 bit
//
// pipeline: 3 front stages, 32 square root stages (divide runs alongside),
// 15 cosine quotient stages, 1 output register
// one transfer per cycle in each direction while m_tready is high
// a stall freezes the whole pipeline, bubbles included
// synchronous active-low reset clears the valid bits only
module vector3_alu (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // a_x, a_y, a_z, b_x, b_y, b_z, scale
    input  logic [111:0] s_tdata,
    // opcode
    input  logic [3:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // res_x, res_y, res_z, cosine, flag, status, 5 zero bits
    output logic [71:0]  m_tdata
);
    import v3a_pkg::*;

    logic        adv;
    logic        f_valid, i_valid, c_valid;
    work_t       f_work, i_work, c_work;
    logic        m_valid_reg;
    logic [71:0] m_data_reg, m_data_next;

    assign adv      = !m_valid_reg || m_tready;
    assign s_tready = adv;

    v3a_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (s_tvalid),
        .in_op     (s_tuser),
        .in_data   (s_tdata),
        .out_valid (f_valid),
        .out_work  (f_work)
    );

    v3a_iter u_iter (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (f_valid),
        .in_work   (f_work),
        .out_valid (i_valid),
        .out_work  (i_work)
    );

    v3a_cosdiv u_cosdiv (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (i_valid),
        .in_work   (i_work),
        .out_valid (c_valid),
        .out_work  (c_work)
    );

    always_comb begin
        logic [2:0][15:0] rv;
        logic [2:0][15:0] dv;
        logic [16:0]      sr;
        logic             dsat;
        logic [14:0]      cq;
        logic [15:0]      cv;
        logic             fl;
        logic [1:0]       st;
        dsat = 1'b0;
        for (int i = 0; i < 3; i++) begin
            sr = c_work.div_neg[i] ? sat16(-34'(c_work.div_num[i]))
                                   : sat16(34'(c_work.div_num[i]));
            dv[i] = sr[15:0];
            dsat  = dsat | sr[16];
        end
        cq = (c_work.cos_q > COS_ONE) ? COS_ONE : c_work.cos_q;
        cv = c_work.d_neg ? -16'(cq) : 16'(cq);
        rv = '0;
        fl = 1'b0;
        st = ST_OK;
        unique case (c_work.op)
            OP_ADD, OP_SUB, OP_CROSS, OP_SCALE: begin
                rv = c_work.vres;
                st = c_work.vsat ? ST_SAT : ST_OK;
            end
            OP_DIV: begin
                if (c_work.dz) begin
                    st = ST_DIVZ;
                end else begin
                    rv = dv;
                    st = dsat ? ST_SAT : ST_OK;
                end
            end
            OP_COS: begin
                st = c_work.dz ? ST_DIVZ : ST_OK;
            end
            OP_GT, OP_GE, OP_LT, OP_LE, OP_EQ, OP_NE: begin
                fl = c_work.flag;
            end
            default: begin
                rv = '0;
            end
        endcase
        if (c_work.op != OP_COS || c_work.dz) begin
            cv = '0;
        end
        m_data_next = {5'b0, st, fl, cv, rv[2], rv[1], rv[0]};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= c_valid;
        end
        if (adv) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

// ----- rtl/v3a_front.sv -----
module v3a_front (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           adv,
    input  logic           in_valid,
    input  logic [3:0]     in_op,
    input  logic [111:0]   in_data,
    output logic           out_valid,
    output v3a_pkg::work_t out_work
);
    import v3a_pkg::*;

    logic signed [15:0] a_in [3];
    logic signed [15:0] b_in [3];
    logic signed [15:0] s_in;

    logic               v1_reg, v2_reg, v3_reg;
    logic [3:0]         op1_reg;
    logic signed [15:0] a1_reg [3];
    logic signed [15:0] b1_reg [3];
    logic signed [31:0] cp_reg [3][2];
    logic signed [31:0] dp_reg [3];
    logic [31:0]        aa_reg [3];
    logic [31:0]        bb_reg [3];
    logic signed [31:0] sp_reg [3];

    work_t       w2_next, w2_reg, w3_next, w3_reg;
    logic [31:0] la_next, lb_next, la2_reg, lb2_reg;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            a_in[i] = in_data[16*i +: 16];
            b_in[i] = in_data[48 + 16*i +: 16];
        end
        s_in = in_data[96 +: 16];
    end

    // stage 1: products
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= in_valid;
        end
        if (adv) begin
            op1_reg      <= in_op;
            cp_reg[0][0] <= a_in[1] * b_in[2];
            cp_reg[0][1] <= a_in[2] * b_in[1];
            cp_reg[1][0] <= a_in[2] * b_in[0];
            cp_reg[1][1] <= a_in[0] * b_in[2];
            cp_reg[2][0] <= a_in[0] * b_in[1];
            cp_reg[2][1] <= a_in[1] * b_in[0];
            for (int i = 0; i < 3; i++) begin
                a1_reg[i] <= a_in[i];
                b1_reg[i] <= b_in[i];
                dp_reg[i] <= a_in[i] * b_in[i];
                aa_reg[i] <= a_in[i] * a_in[i];
                bb_reg[i] <= b_in[i] * b_in[i];
                sp_reg[i] <= a_in[i] * s_in;
            end
        end
    end

    // stage 2: sums, rounding, saturation, compares
    always_comb begin
        logic [16:0]        sr;
        logic signed [33:0] dsum;
        logic               same;
        logic               bzero;
        w2_next    = '0;
        w2_next.op = op1_reg;
        la_next    = aa_reg[0] + aa_reg[1] + aa_reg[2];
        lb_next    = bb_reg[0] + bb_reg[1] + bb_reg[2];
        same       = 1'b1;
        bzero      = 1'b0;
        for (int i = 0; i < 3; i++) begin
            unique case (op1_reg)
                OP_ADD:   sr = sat16(34'(a1_reg[i]) + 34'(b1_reg[i]));
                OP_SUB:   sr = sat16(34'(a1_reg[i]) - 34'(b1_reg[i]));
                OP_CROSS: sr = sat16(rnd8(34'(cp_reg[i][0]) - 34'(cp_reg[i][1])));
                OP_SCALE: sr = sat16(rnd8(34'(sp_reg[i])));
                default:  sr = '0;
            endcase
            w2_next.vres[i] = sr[15:0];
            w2_next.vsat    = w2_next.vsat | sr[16];
            w2_next.div_num[i] = {(a1_reg[i][15] ? 16'(-a1_reg[i]) : 16'(a1_reg[i])), 8'h00};
            w2_next.div_den[i] = b1_reg[i][15] ? 16'(-b1_reg[i]) : 16'(b1_reg[i]);
            w2_next.div_neg[i] = a1_reg[i][15] ^ b1_reg[i][15];
            same  = same & (a1_reg[i] == b1_reg[i]);
            bzero = bzero | (b1_reg[i] == 16'sd0);
        end
        dsum = 34'(dp_reg[0]) + 34'(dp_reg[1]) + 34'(dp_reg[2]);
        w2_next.d_neg = dsum[33];
        w2_next.mag   = dsum[33] ? 32'(-dsum) : 32'(dsum);
        unique case (op1_reg)
            OP_GT:   w2_next.flag = la_next > lb_next;
            OP_GE:   w2_next.flag = la_next >= lb_next;
            OP_LT:   w2_next.flag = la_next < lb_next;
            OP_LE:   w2_next.flag = la_next <= lb_next;
            OP_EQ:   w2_next.flag = same;
            OP_NE:   w2_next.flag = !same;
            default: w2_next.flag = 1'b0;
        endcase
        unique case (op1_reg)
            OP_DIV:  w2_next.dz = bzero;
            OP_COS:  w2_next.dz = (la_next == 32'd0) || (lb_next == 32'd0);
            default: w2_next.dz = 1'b0;
        endcase
    end

    // stage 3: product of squared lengths
    always_comb begin
        w3_next       = w2_reg;
        w3_next.sq_op = la2_reg * lb2_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (adv) begin
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
        if (adv) begin
            w2_reg  <= w2_next;
            la2_reg <= la_next;
            lb2_reg <= lb_next;
            w3_reg  <= w3_next;
        end
    end

    assign out_valid = v3_reg;
    assign out_work  = w3_reg;

endmodule

// ----- rtl/v3a_iter.sv -----
module v3a_iter (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           adv,
    input  logic           in_valid,
    input  v3a_pkg::work_t in_work,
    output logic           out_valid,
    output v3a_pkg::work_t out_work
);
    import v3a_pkg::*;

    work_t w_reg [SqSteps];
    logic  v_reg [SqSteps];

    // one square root step per stage, one quotient bit in each of the first DivSteps stages
    for (genvar k = 0; k < SqSteps; k++) begin : g_stage
        work_t            cur, nxt;
        logic             vin;
        logic [63:0]      one_v, trial;
        logic [2:0][16:0] dt;

        if (k == 0) begin : g_first
            assign cur = in_work;
            assign vin = in_valid;
        end else begin : g_rest
            assign cur = w_reg[k-1];
            assign vin = v_reg[k-1];
        end

        always_comb begin
            nxt   = cur;
            one_v = 64'd1 << (2*SqSteps - 2 - 2*k);
            trial = cur.sq_res + one_v;
            dt    = '0;
            if (cur.sq_op >= trial) begin
                nxt.sq_op  = cur.sq_op - trial;
                nxt.sq_res = (cur.sq_res >> 1) + one_v;
            end else begin
                nxt.sq_res = cur.sq_res >> 1;
            end
            if (k < DivSteps) begin
                for (int i = 0; i < 3; i++) begin
                    dt[i] = {cur.div_rem[i], cur.div_num[i][23]};
                    if (dt[i] >= {1'b0, cur.div_den[i]}) begin
                        nxt.div_rem[i] = 16'(dt[i] - {1'b0, cur.div_den[i]});
                        nxt.div_num[i] = {cur.div_num[i][22:0], 1'b1};
                    end else begin
                        nxt.div_rem[i] = dt[i][15:0];
                        nxt.div_num[i] = {cur.div_num[i][22:0], 1'b0};
                    end
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[k] <= 1'b0;
            end else if (adv) begin
                v_reg[k] <= vin;
            end
            if (adv) begin
                w_reg[k] <= nxt;
            end
        end
    end

    assign out_valid = v_reg[SqSteps-1];
    assign out_work  = w_reg[SqSteps-1];

endmodule

// ----- rtl/v3a_cosdiv.sv -----
module v3a_cosdiv (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           adv,
    input  logic           in_valid,
    input  v3a_pkg::work_t in_work,
    output logic           out_valid,
    output v3a_pkg::work_t out_work
);
    import v3a_pkg::*;

    work_t w_reg [CosSteps];
    logic  v_reg [CosSteps];

    // restoring division of |a.b| by the root, one quotient bit per stage
    for (genvar j = 0; j < CosSteps; j++) begin : g_stage
        work_t       cur, nxt;
        logic        vin;
        logic [32:0] t, root;

        if (j == 0) begin : g_first
            assign cur = in_work;
            assign vin = in_valid;
        end else begin : g_rest
            assign cur = w_reg[j-1];
            assign vin = v_reg[j-1];
        end

        always_comb begin
            nxt  = cur;
            root = {1'b0, cur.sq_res[31:0]};
            t    = (j == 0) ? {1'b0, cur.mag} : {cur.cos_rem, 1'b0};
            if (t >= root) begin
                nxt.cos_rem = 32'(t - root);
                nxt.cos_q   = {cur.cos_q[13:0], 1'b1};
            end else begin
                nxt.cos_rem = t[31:0];
                nxt.cos_q   = {cur.cos_q[13:0], 1'b0};
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[j] <= 1'b0;
            end else if (adv) begin
                v_reg[j] <= vin;
            end
            if (adv) begin
                w_reg[j] <= nxt;
            end
        end
    end

    assign out_valid = v_reg[CosSteps-1];
    assign out_work  = w_reg[CosSteps-1];

endmodule

// ----- sim/testbench.sv -----
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import v3a_pkg::*;

    typedef struct packed {
        logic [3:0]  op;
        logic [15:0] ax, ay, az, bx, by, bz, sc;
    } vec_op_t;

    typedef struct packed {
        logic [15:0] rx, ry, rz, cosv;
        logic        flag;
        logic [1:0]  status;
    } vec_res_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [111:0] s_tdata = '0;
    logic [3:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [71:0]  m_tdata;

    vec_op_t  pending_ops[$];
    vec_res_t expected_res[$];
    int       errors = 0;
    int       send_idle_pct = 37;
    int       recv_idle_pct = 48;
    bit       hold_off = 1'b0;

    vector3_alu dut (.*);

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic longint sx(logic [15:0] v);
        return longint'(signed'(v));
    endfunction

    function automatic longint rnd_q8(longint v);
        longint t;
        t = v + 128;
        return t >= 0 ? t / 256 : -((-t + 255) / 256);
    endfunction

    function automatic logic [15:0] clamp16(longint v, ref bit sat);
        if (v > 32767) begin
            sat = 1'b1;
            return 16'h7fff;
        end
        if (v < -32768) begin
            sat = 1'b1;
            return 16'h8000;
        end
        return v[15:0];
    endfunction

    function automatic longint unsigned root64(longint unsigned v);
        longint unsigned r, one;
        r = 0;
        one = 64'd1 << 62;
        while (one > v) one >>= 2;
        while (one != 0) begin
            if (v >= r + one) begin
                v -= r + one;
                r = (r >> 1) + one;
            end else begin
                r >>= 1;
            end
            one >>= 2;
        end
        return r;
    endfunction

    function automatic vec_res_t compute_vector(vec_op_t it);
        vec_res_t     r;
        longint       a[3], b[3], s, la, lb, d, v;
        longint unsigned rt, mag, q;
        bit           sat;
        r = '0;
        sat = 1'b0;
        a[0] = sx(it.ax); a[1] = sx(it.ay); a[2] = sx(it.az);
        b[0] = sx(it.bx); b[1] = sx(it.by); b[2] = sx(it.bz);
        s = sx(it.sc);
        la = a[0]*a[0] + a[1]*a[1] + a[2]*a[2];
        lb = b[0]*b[0] + b[1]*b[1] + b[2]*b[2];
        case (it.op)
            OP_ADD, OP_SUB: begin
                r.rx = clamp16(it.op == OP_ADD ? a[0] + b[0] : a[0] - b[0], sat);
                r.ry = clamp16(it.op == OP_ADD ? a[1] + b[1] : a[1] - b[1], sat);
                r.rz = clamp16(it.op == OP_ADD ? a[2] + b[2] : a[2] - b[2], sat);
            end
            OP_CROSS: begin
                r.rx = clamp16(rnd_q8(a[1]*b[2] - a[2]*b[1]), sat);
                r.ry = clamp16(rnd_q8(a[2]*b[0] - a[0]*b[2]), sat);
                r.rz = clamp16(rnd_q8(a[0]*b[1] - a[1]*b[0]), sat);
            end
            OP_SCALE: begin
                r.rx = clamp16(rnd_q8(a[0]*s), sat);
                r.ry = clamp16(rnd_q8(a[1]*s), sat);
                r.rz = clamp16(rnd_q8(a[2]*s), sat);
            end
            OP_DIV: begin
                if (b[0] == 0 || b[1] == 0 || b[2] == 0) begin
                    r.status = ST_DIVZ;
                end else begin
                    r.rx = clamp16((a[0]*256) / b[0], sat);
                    r.ry = clamp16((a[1]*256) / b[1], sat);
                    r.rz = clamp16((a[2]*256) / b[2], sat);
                end
            end
            OP_COS: begin
                if (la == 0 || lb == 0) begin
                    r.status = ST_DIVZ;
                end else begin
                    d = a[0]*b[0] + a[1]*b[1] + a[2]*b[2];
                    rt = root64(longint'(unsigned'(la)) * longint'(unsigned'(lb)));
                    if (rt == 0) rt = 1;
                    mag = d < 0 ? -d : d;
                    q = (mag * 16384) / rt;
                    if (q > 16384) q = 16384;
                    v = d < 0 ? -longint'(q) : longint'(q);
                    r.cosv = v[15:0];
                end
            end
            OP_GT: r.flag = la > lb;
            OP_GE: r.flag = la >= lb;
            OP_LT: r.flag = la < lb;
            OP_LE: r.flag = la <= lb;
            OP_EQ: r.flag = a[0] == b[0] && a[1] == b[1] && a[2] == b[2];
            OP_NE: r.flag = !(a[0] == b[0] && a[1] == b[1] && a[2] == b[2]);
            default: ;
        endcase
        if (sat && r.status == ST_OK) r.status = ST_SAT;
        return r;
    endfunction

    function automatic vec_op_t bus_to_op(logic [3:0] op, logic [111:0] d);
        vec_op_t it;
        it.op = op;
        it.ax = d[15:0];
        it.ay = d[31:16];
        it.az = d[47:32];
        it.bx = d[63:48];
        it.by = d[79:64];
        it.bz = d[95:80];
        it.sc = d[111:96];
        return it;
    endfunction

    task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
        $display("mismatch %s: got %h expected %h", what, got, want);
        errors++;
    endtask

    task automatic queue_op(vec_op_t it);
        pending_ops = {pending_ops, it};
    endtask

    // driver
    always @(posedge aclk) begin
        vec_op_t it;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                expected_res = {expected_res, compute_vector(bus_to_op(s_tuser, s_tdata))};
            end
            if (!s_tvalid || s_tready) begin
                if (pending_ops.size() != 0 && !hold_off
                        && $urandom_range(99) >= send_idle_pct) begin
                    it = pending_ops.pop_front();
                    s_tuser <= it.op;
                    s_tdata <= {it.sc, it.bz, it.by, it.bx, it.az, it.ay, it.ax};
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        vec_res_t got, want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got.rx     = m_tdata[15:0];
                got.ry     = m_tdata[31:16];
                got.rz     = m_tdata[47:32];
                got.cosv   = m_tdata[63:48];
                got.flag   = m_tdata[64];
                got.status = m_tdata[66:65];
                if (expected_res.size() == 0) begin
                    report_mismatch("unexpected transfer", got.rx, 16'h0);
                end else begin
                    want = expected_res.pop_front();
                    if (got.rx !== want.rx) report_mismatch("res_x", got.rx, want.rx);
                    if (got.ry !== want.ry) report_mismatch("res_y", got.ry, want.ry);
                    if (got.rz !== want.rz) report_mismatch("res_z", got.rz, want.rz);
                    if (got.cosv !== want.cosv) report_mismatch("cosine", got.cosv, want.cosv);
                    if (got.flag !== want.flag)
                        report_mismatch("flag", 16'(got.flag), 16'(want.flag));
                    if (got.status !== want.status)
                        report_mismatch("status", 16'(got.status), 16'(want.status));
                end
                if (m_tdata[71:67] !== 5'd0)
                    report_mismatch("pad", 16'(m_tdata[71:67]), 16'h0);
            end
            m_tready <= $urandom_range(99) >= recv_idle_pct;
        end
    end

    function automatic logic [15:0] pick_comp();
        case ($urandom_range(9))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            3, 4: return 16'(signed'($urandom_range(2048)) - 1024);
            5: return 16'(signed'($urandom_range(512)) - 256);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic vec_op_t random_op();
        vec_op_t it;
        it.op = $urandom_range(99) < 4 ? 4'($urandom_range(15, 12)) : 4'($urandom_range(11));
        it.ax = pick_comp(); it.ay = pick_comp(); it.az = pick_comp();
        it.bx = pick_comp(); it.by = pick_comp(); it.bz = pick_comp();
        it.sc = pick_comp();
        if (it.op inside {OP_EQ, OP_NE} && $urandom_range(1)) begin
            it.bx = it.ax; it.by = it.ay;
            if ($urandom_range(1)) it.bz = it.az;
        end
        if (it.op inside {OP_GE, OP_LE} && $urandom_range(3) == 0) begin
            it.bx = it.ay; it.by = it.az; it.bz = it.ax;
        end
        return it;
    endfunction

    task automatic wait_drained();
        while (pending_ops.size() != 0 || s_tvalid || expected_res.size() != 0)
            @(negedge aclk);
    endtask

    initial begin
        vec_op_t it;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        for (int op = 0; op < 16; op++) begin
            it = '{4'(op), 16'h7fff, 16'h8000, 16'h0100, 16'h7fff, 16'h7fff,
                   16'hff00, 16'h8000};
            queue_op(it);
        end
        // zero divisor element, zero-length vector, antiparallel and equal vectors, equal lengths, scale rounding
        queue_op('{OP_DIV, 16'h0100, 16'h0200, 16'h0300, 16'h0100,
                   16'h0000, 16'h0100, 16'h0000});
        queue_op('{OP_COS, 16'h0000, 16'h0000, 16'h0000, 16'h0100,
                   16'h0100, 16'h0100, 16'h0000});
        queue_op('{OP_COS, 16'h0100, 16'h0200, 16'h0300, 16'hfe00,
                   16'hfc00, 16'hfa00, 16'h0000});
        queue_op('{OP_EQ, 16'h1234, 16'h8000, 16'h7fff, 16'h1234,
                   16'h8000, 16'h7fff, 16'hffff});
        queue_op('{OP_GE, 16'h0100, 16'h0000, 16'h0000, 16'h0000,
                   16'hff00, 16'h0000, 16'h0000});
        queue_op('{OP_SCALE, 16'hffff, 16'h0001, 16'h8000, 16'h0000,
                   16'h0000, 16'h0000, 16'h0080});
        wait_drained();

        // sender holds off while twenty random operations are queued, then resumes
        hold_off = 1'b1;
        for (int i = 0; i < 20; i++) queue_op(random_op());
        repeat (3) @(posedge aclk);
        hold_off = 1'b0;

        for (int i = 0; i < 480; i++) queue_op(random_op());
        wait_drained();
        hold_off = 1'b1;
        wait_drained();
        hold_off = 1'b0;

        send_idle_pct = 48;
        recv_idle_pct = 37;
        for (int i = 0; i < 480; i++) queue_op(random_op());
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (int i = 0; i < 480; i++) queue_op(random_op());
        wait_drained();
        repeat (60) @(posedge aclk);

        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("[FAIL] regression broken");
        $finish;
    end
endmodule
